// File: rtl/core/eqdt_pkg.sv
// Shared constants, codes and control structs for the event queue with delay timers.
`default_nettype none

package eqdt_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIMER_COUNT = 8;
    localparam logic [7:0] NONE_EVENT = 8'd0;

    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int TIMER_IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    localparam logic [2:0] ACT_POST  = 3'd0;
    localparam logic [2:0] ACT_GET   = 3'd1;
    localparam logic [2:0] ACT_TICK  = 3'd2;
    localparam logic [2:0] ACT_ARM   = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;

    typedef struct packed {
        logic       post;
        logic       get;
        logic [7:0] data;
    } queue_cmd_t;

    typedef struct packed {
        logic waiting;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic                   arm;
        logic                   clear;
        logic                   step;
        logic [TIMER_IDX_W-1:0] idx;
        logic [7:0]             evt;
        logic [31:0]            delay;
    } timer_cmd_t;

    typedef struct packed {
        logic       expire;
        logic [7:0] evt;
    } timer_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/event_queue_with_delay_timers.sv
// Top level: command sequencer over the event queue and the delay timer bank.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  command  | start / busy       | action, event_code, timer_index, delay_ms
//  result   | done (1-cycle)     | event_out, status, dropped_count, waiting,
//           |                    | queue_full
//
//  A command is taken at a clock edge with start high and busy low.
//  Post, get, arm, clear and unused codes: S_EXEC, then S_FIN with done high;
//  the next command is taken once the block is back in S_IDLE.
//  Tick: the timer walk visits one timer per cycle through the shared
//  decrementer in S_WALK, between S_EXEC and S_FIN, where done is high.
//  Reset clears the queue indices, full flag and all timers; no clearing pass.
//  The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module event_queue_with_delay_timers (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [7:0]  event_code,
    input  wire logic [2:0]  timer_index,
    input  wire logic [31:0] delay_ms,
    output logic             done,
    output logic [7:0]       event_out,
    output logic [1:0]       status,
    output logic [3:0]       dropped_count,
    output logic             waiting,
    output logic             queue_full
);
    import eqdt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [TIMER_IDX_W-1:0] walk_reg;
    logic [TIMER_IDX_W-1:0] walk_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [3:0]             dropped_reg;
    logic [3:0]             dropped_next;
    logic                   got_reg;
    logic                   got_next;

    logic [2:0]             action_reg;
    logic [7:0]             evt_reg;
    logic [2:0]             tix_reg;
    logic [31:0]            delay_reg;

    queue_cmd_t             q_cmd;
    queue_stat_t            q_stat;
    logic [7:0]             q_rd_data;
    timer_cmd_t             t_cmd;
    timer_stat_t            t_stat;
    logic                   tix_ok;

    assign tix_ok = (32'(tix_reg) < 32'(TIMER_COUNT));

    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        status_next  = status_reg;
        dropped_next = dropped_reg;
        got_next     = got_reg;

        q_cmd.post  = 1'b0;
        q_cmd.get   = 1'b0;
        q_cmd.data  = evt_reg;

        t_cmd.arm   = 1'b0;
        t_cmd.clear = 1'b0;
        t_cmd.step  = 1'b0;
        t_cmd.idx   = TIMER_IDX_W'(tix_reg);
        t_cmd.evt   = evt_reg;
        t_cmd.delay = delay_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next   = S_EXEC;
                    status_next  = STAT_OK;
                    dropped_next = '0;
                    got_next     = 1'b0;
                    walk_next    = '0;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                unique case (action_reg)
                    ACT_POST:
                    begin
                        q_cmd.post = 1'b1;
                        if (q_stat.full)
                        begin
                            status_next  = STAT_DROPPED;
                            dropped_next = 4'd1;
                        end
                    end
                    ACT_GET:
                    begin
                        q_cmd.get = 1'b1;
                        if (q_stat.waiting)
                        begin
                            got_next = 1'b1;
                        end
                        else
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    ACT_TICK:
                    begin
                        state_next = S_WALK;
                    end
                    ACT_ARM:
                    begin
                        t_cmd.arm = tix_ok;
                    end
                    ACT_CLEAR:
                    begin
                        t_cmd.clear = tix_ok;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WALK:
            begin
                t_cmd.idx  = walk_reg;
                t_cmd.step = 1'b1;
                q_cmd.data = t_stat.evt;
                q_cmd.post = t_stat.expire;
                if (t_stat.expire && q_stat.full)
                begin
                    status_next = STAT_DROPPED;
                    if (dropped_reg != 4'd15)
                    begin
                        dropped_next = dropped_reg + 4'd1;
                    end
                end
                if (walk_reg == TIMER_IDX_W'(TIMER_COUNT - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    walk_next = walk_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            walk_reg    <= '0;
            status_reg  <= STAT_OK;
            dropped_reg <= '0;
            got_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            status_reg  <= status_next;
            dropped_reg <= dropped_next;
            got_reg     <= got_next;
        end
    end

    // Hold the command fields for the whole operation.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            action_reg <= action;
            evt_reg    <= event_code;
            tix_reg    <= timer_index;
            delay_reg  <= delay_ms;
        end
    end

    eqdt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_cmd),
        .stat    (q_stat),
        .rd_data (q_rd_data)
    );

    eqdt_timer_bank u_timers (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (t_cmd),
        .stat  (t_stat)
    );

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_FIN);
    assign event_out     = got_reg ? q_rd_data : NONE_EVENT;
    assign status        = status_reg;
    assign dropped_count = dropped_reg;
    assign waiting       = q_stat.waiting;
    assign queue_full    = q_stat.full;

endmodule

`default_nettype wire

// File: rtl/core/eqdt_queue.sv
// Circular event queue: storage array, read/write indices and full flag.
`default_nettype none

module eqdt_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire eqdt_pkg::queue_cmd_t  cmd,
    output eqdt_pkg::queue_stat_t   stat,
    output logic [7:0]              rd_data
);
    import eqdt_pkg::*;

    logic [7:0]             mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] rd_idx_reg;
    logic [QUEUE_IDX_W-1:0] rd_idx_next;
    logic [QUEUE_IDX_W-1:0] wr_idx_reg;
    logic [QUEUE_IDX_W-1:0] wr_idx_next;
    logic                   full_reg;
    logic                   full_next;
    logic [7:0]             rd_data_reg;
    logic                   waiting;
    logic [QUEUE_IDX_W-1:0] wr_inc;
    logic [QUEUE_IDX_W-1:0] rd_inc;

    assign waiting = full_reg || (rd_idx_reg != wr_idx_reg);
    assign wr_inc  = (wr_idx_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign rd_inc  = (rd_idx_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        full_next   = full_reg;
        if (cmd.post && !full_reg)
        begin
            wr_idx_next = wr_inc;
            full_next   = (wr_inc == rd_idx_reg);
        end
        else if (cmd.get && waiting)
        begin
            rd_idx_next = rd_inc;
            full_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            full_reg   <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post && !full_reg)
        begin
            mem[wr_idx_reg] <= cmd.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.get && waiting)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    assign stat.waiting = waiting;
    assign stat.full    = full_reg;
    assign rd_data      = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/eqdt_timer_bank.sv
// Delay timer bank with one shared decrementer, stepped one timer per cycle.
`default_nettype none

module eqdt_timer_bank (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire eqdt_pkg::timer_cmd_t  cmd,
    output eqdt_pkg::timer_stat_t   stat
);
    import eqdt_pkg::*;

    logic [31:0] count_reg [TIMER_COUNT];
    logic [7:0]  evt_reg   [TIMER_COUNT];
    logic [31:0] sel_count;
    logic [31:0] dec_count;
    logic        sel_busy;

    assign sel_count = count_reg[cmd.idx];
    assign sel_busy  = (sel_count != 32'd0);
    assign dec_count = sel_count - 32'd1;

    // A count of one steps to zero now: the timer fires.
    assign stat.expire = cmd.step && (sel_count == 32'd1);
    assign stat.evt    = evt_reg[cmd.idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                count_reg[i] <= '0;
                evt_reg[i]   <= NONE_EVENT;
            end
        end
        else
        begin
            if (cmd.arm)
            begin
                count_reg[cmd.idx] <= cmd.delay;
                evt_reg[cmd.idx]   <= cmd.evt;
            end
            else if (cmd.clear)
            begin
                count_reg[cmd.idx] <= '0;
                evt_reg[cmd.idx]   <= NONE_EVENT;
            end
            else if (cmd.step && sel_busy)
            begin
                count_reg[cmd.idx] <= dec_count;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/eqdt_checker.sv
// Port-level checker for the event queue with delay timers, bound to the top level.
`default_nettype none

module eqdt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [3:0]  dropped_count,
    input wire logic        waiting,
    input wire logic        queue_full
);
    import eqdt_pkg::*;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside an operation");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_empty_get: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EMPTY) |-> (!waiting && !queue_full))
        else $error("empty get reported while queue holds events");

    a_ok_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_OK) |-> (dropped_count == 4'd0))
        else $error("drops counted with ok status");

    a_full_waits: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!queue_full || waiting))
        else $error("full queue reported as empty");

endmodule

bind event_queue_with_delay_timers eqdt_checker u_eqdt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .dropped_count (dropped_count),
    .waiting       (waiting),
    .queue_full    (queue_full)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the event queue with delay timers.
`timescale 1ns / 100ps

module testbench;
    import eqdt_pkg::*;

    typedef struct packed {
        logic [7:0] evt;
        logic [1:0] stat;
        logic [3:0] drops;
        logic       waiting;
        logic       full;
    } step_outcome_t;

    class eqdt_scoreboard;
        logic [7:0]             queue_mem [QUEUE_DEPTH];
        logic [QUEUE_IDX_W-1:0] rd_ptr;
        logic [QUEUE_IDX_W-1:0] wr_ptr;
        logic                   full_q;
        logic [31:0]            timer_cnt [TIMER_COUNT];
        logic [7:0]             timer_evt [TIMER_COUNT];
        step_outcome_t          outcome_fifo [$];
        int                     errors;

        function void clear_state();
            rd_ptr = '0;
            wr_ptr = '0;
            full_q = 1'b0;
            errors = 0;
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                timer_cnt[i] = '0;
                timer_evt[i] = NONE_EVENT;
            end
        endfunction

        // Store one event; return 0 when the queue is full and the event is lost.
        function bit push_event(logic [7:0] ev);
            if (full_q)
                return 1'b0;
            queue_mem[wr_ptr] = ev;
            wr_ptr = wr_ptr + 1'b1;
            if (wr_ptr == rd_ptr)
                full_q = 1'b1;
            return 1'b1;
        endfunction

        // Apply one accepted command and queue the outcome it must produce.
        function void note_command(logic [2:0] act, logic [7:0] ev, logic [2:0] tix,
                                   logic [31:0] dly);
            step_outcome_t r;
            r.evt   = NONE_EVENT;
            r.stat  = STAT_OK;
            r.drops = 4'd0;
            unique case (act)
                ACT_POST:
                begin
                    if (!push_event(ev))
                    begin
                        r.stat  = STAT_DROPPED;
                        r.drops = 4'd1;
                    end
                end
                ACT_GET:
                begin
                    if (!full_q && rd_ptr == wr_ptr)
                        r.stat = STAT_EMPTY;
                    else
                    begin
                        r.evt  = queue_mem[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        full_q = 1'b0;
                    end
                end
                ACT_TICK:
                begin
                    for (int i = 0; i < TIMER_COUNT; i++)
                    begin
                        if (timer_cnt[i] != 0)
                        begin
                            timer_cnt[i] = timer_cnt[i] - 32'd1;
                            if (timer_cnt[i] == 0 && !push_event(timer_evt[i]))
                            begin
                                if (r.drops != 4'd15)
                                    r.drops = r.drops + 1'b1;
                                r.stat = STAT_DROPPED;
                            end
                        end
                    end
                end
                ACT_ARM:
                begin
                    if (tix < TIMER_COUNT)
                    begin
                        timer_cnt[tix] = dly;
                        timer_evt[tix] = ev;
                    end
                end
                ACT_CLEAR:
                begin
                    if (tix < TIMER_COUNT)
                    begin
                        timer_cnt[tix] = '0;
                        timer_evt[tix] = NONE_EVENT;
                    end
                end
                default: ;
            endcase
            r.waiting = full_q || (rd_ptr != wr_ptr);
            r.full    = full_q;
            outcome_fifo.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_outcome(logic [7:0] evt, logic [1:0] stat, logic [3:0] drops,
                           logic waiting, logic full);
            step_outcome_t e;
            if (outcome_fifo.size() == 0)
            begin
                report_mismatch("result with no command outstanding");
                return;
            end
            e = outcome_fifo.pop_front();
            if (evt !== e.evt)
                report_mismatch($sformatf("event_out %h, want %h", evt, e.evt));
            if (stat !== e.stat)
                report_mismatch($sformatf("status %0d, want %0d", stat, e.stat));
            if (drops !== e.drops)
                report_mismatch($sformatf("dropped_count %0d, want %0d", drops, e.drops));
            if (waiting !== e.waiting)
                report_mismatch($sformatf("waiting %b, want %b", waiting, e.waiting));
            if (full !== e.full)
                report_mismatch($sformatf("queue_full %b, want %b", full, e.full));
        endtask
    endclass

    localparam int ITEM_TARGET = 1400;
    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  action = 3'd0;
    logic [7:0]  event_code = 8'd0;
    logic [2:0]  timer_index = 3'd0;
    logic [31:0] delay_ms = 32'd0;
    logic        busy;
    logic        done;
    logic [7:0]  event_out;
    logic [1:0]  status;
    logic [3:0]  dropped_count;
    logic        waiting;
    logic        queue_full;

    eqdt_scoreboard sb;
    int             gap_pct = 33;
    int             items_sent = 0;
    int             quiet_cycles = 0;

    event_queue_with_delay_timers i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .event_code    (event_code),
        .timer_index   (timer_index),
        .delay_ms      (delay_ms),
        .done          (done),
        .event_out     (event_out),
        .status        (status),
        .dropped_count (dropped_count),
        .waiting       (waiting),
        .queue_full    (queue_full)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        sb = new;
        sb.clear_state();
    end

    // Sample every transfer and every result at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(action, event_code, timer_index, delay_ms);
            if (done)
                sb.check_outcome(event_out, status, dropped_count, waiting, queue_full);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send(input logic [2:0] act, input logic [7:0] ev,
                        input logic [2:0] tix, input logic [31:0] dly);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        event_code  <= ev;
        timer_index <= tix;
        delay_ms    <= dly;
        do
            @(posedge clk);
        while (busy);
        if (act <= ACT_CLEAR)
            items_sent++;
    endtask

    // Hold off until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.outcome_fifo.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_delay();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7)
            return $urandom_range(4);
        else if (sel < 9)
            return $urandom_range(40);
        return $urandom;
    endfunction

    task automatic random_sequence();
        int kind;
        int n;
        kind = $urandom_range(9);
        unique case (kind)
            0, 1, 2:
            begin
                n = $urandom_range(1, 20);
                repeat (n) send(ACT_POST, 8'($urandom), 3'($urandom), $urandom);
            end
            3, 4:
            begin
                n = $urandom_range(1, 20);
                repeat (n) send(ACT_GET, 8'($urandom), 3'($urandom), $urandom);
            end
            5, 6:
            begin
                n = $urandom_range(1, 8);
                repeat (n) send(ACT_ARM, 8'($urandom), 3'($urandom), pick_delay());
                n = $urandom_range(1, 6);
                repeat (n) send(ACT_TICK, 8'($urandom), 3'($urandom), $urandom);
            end
            7:
            begin
                n = $urandom_range(1, 4);
                repeat (n) send(ACT_CLEAR, 8'($urandom), 3'($urandom), $urandom);
                send(ACT_TICK, 8'($urandom), 3'($urandom), $urandom);
            end
            8:
            begin
                n = $urandom_range(1, 6);
                repeat (n) send(3'($urandom), 8'($urandom), 3'($urandom), $urandom);
            end
            default:
            begin
                n = $urandom_range(1, 5);
                repeat (n) send(ACT_TICK, 8'($urandom), 3'($urandom), $urandom);
            end
        endcase
    endtask

    initial
    begin : stimulus
        int phase_pct [3];
        phase_pct = '{33, 74, 0};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every action, timer corner cases.
        send(ACT_GET,   8'h00, 3'd0, 32'd0);
        send(ACT_POST,  8'h00, 3'd0, 32'd0);
        send(ACT_POST,  8'hFF, 3'd7, 32'hFFFF_FFFF);
        send(ACT_ARM,   8'h11, 3'd0, 32'd1);
        send(ACT_ARM,   8'hEE, 3'd7, 32'hFFFF_FFFF);
        send(ACT_ARM,   8'h33, 3'd3, 32'd0);
        send(ACT_ARM,   8'h55, 3'd5, 32'd2);
        send(ACT_TICK,  8'h00, 3'd0, 32'd0);
        send(ACT_TICK,  8'hFF, 3'd7, 32'hFFFF_FFFF);
        send(ACT_GET,   8'h00, 3'd0, 32'd0);
        send(ACT_GET,   8'h00, 3'd0, 32'd0);
        send(ACT_GET,   8'h00, 3'd0, 32'd0);
        send(ACT_GET,   8'h00, 3'd0, 32'd0);
        send(ACT_GET,   8'h00, 3'd0, 32'd0);
        send(ACT_CLEAR, 8'hFF, 3'd7, 32'hFFFF_FFFF);
        send(ACT_CLEAR, 8'h00, 3'd0, 32'd0);
        send(ACT_TICK,  8'h00, 3'd0, 32'd0);
        send(3'd5,      8'hA5, 3'd2, 32'h5A5A_5A5A);
        send(3'd6,      8'h5A, 3'd5, 32'hA5A5_A5A5);
        send(3'd7,      8'hFF, 3'd7, 32'hFFFF_FFFF);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = phase_pct[phase];
            while (items_sent < 20 + (phase + 1) * (ITEM_TARGET / 3))
                random_sequence();
            drain();
        end

        @(negedge clk);
        start <= 1'b0;
        while (sb.outcome_fifo.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.outcome_fifo.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
